[rtl/rdct_pkg.sv]
// shared types, codes and sizes for the reloading down-counter timer
`default_nettype none
package rdct_pkg;

	localparam int COUNTER_WIDTH   = 24;
	localparam int PRESCALE_DIVIDE = 8;
	localparam int PRESCALE_WIDTH  = (PRESCALE_DIVIDE > 1) ? $clog2(PRESCALE_DIVIDE) : 1;
	localparam int DATA_WIDTH      = 32;

	localparam int CTRL_ENABLE_BIT = 0;
	localparam int CTRL_INT_BIT    = 1;
	localparam int CTRL_CLOCK_BIT  = 2;
	localparam int CTRL_FLAG_BIT   = 16;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_READ   = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_CTRL    = 2'd0,
		REG_RELOAD  = 2'd1,
		REG_CURRENT = 2'd2,
		REG_CALIB   = 2'd3
	} reg_sel_t;

	typedef enum logic {
		CFG_ONE_SHOT = 1'b0,
		CFG_CALIB    = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		cmd_t                  cmd;
		reg_sel_t              sel;
		logic [DATA_WIDTH-1:0] data;
	} req_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] read_data;
		logic                  irq;
		logic                  flag;
	} res_t;

	typedef struct packed {
		logic valid;
		logic advance;
	} flow_t;

endpackage
`default_nettype wire

[rtl/reloading_down_counter_timer_unit.sv]
// top level of the reloading down-counter timer
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------
//  in       | in_valid / in_stall | command, reg_select, write_data
//  out      | out_valid/out_stall | read_data, irq_request, count_flag
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one request per cycle unless stalled; each request and result is registered
// the rate is set by the state update between input and result registers
// arst_n clears the timer state, configuration and both stage valids at once
// a stalled result holds and the input register keeps taking requests until it is full
// cfg_ready is always high; configuration goes straight into its registers
`default_nettype none
module reloading_down_counter_timer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [1:0]  reg_select,
	input  wire logic [31:0] write_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      read_data,
	output logic             irq_request,
	output logic             count_flag,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	rdct_pkg::req_t  in_req, req_s1;
	rdct_pkg::res_t  res, res_s2;
	rdct_pkg::flow_t flow;
	logic            advance;

	assign in_req.cmd  = rdct_pkg::cmd_t'(command);
	assign in_req.sel  = rdct_pkg::reg_sel_t'(reg_select);
	assign in_req.data = write_data;
	assign cfg_ready   = 1'b1;

	rdct_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_req   (in_req),
		.advance  (advance),
		.flow     (flow),
		.req_s1   (req_s1)
	);

	rdct_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (rdct_pkg::cfg_idx_t'(cfg_index)),
		.cfg_wdata (cfg_data),
		.flow      (flow),
		.req_s1    (req_s1),
		.res       (res)
	);

	rdct_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (flow.valid),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_s2    (res_s2)
	);

	assign read_data   = res_s2.read_data;
	assign irq_request = res_s2.irq;
	assign count_flag  = res_s2.flag;

endmodule
`default_nettype wire

[rtl/rdct_in_stage.sv]
// input register stage for timer requests
`default_nettype none
module rdct_in_stage (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire rdct_pkg::req_t in_req,
	input  wire logic        advance,
	output rdct_pkg::flow_t  flow,
	output rdct_pkg::req_t   req_s1
);

	logic valid_s1;

	assign in_stall     = valid_s1 && !advance;
	assign flow.valid   = valid_s1;
	assign flow.advance = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_req;
		end
	end

endmodule
`default_nettype wire

[rtl/rdct_core.sv]
// timer state, configuration registers and per-request update logic
`default_nettype none
module rdct_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire rdct_pkg::cfg_idx_t cfg_idx,
	input  wire logic [rdct_pkg::DATA_WIDTH-1:0] cfg_wdata,
	input  wire rdct_pkg::flow_t flow,
	input  wire rdct_pkg::req_t  req_s1,
	output rdct_pkg::res_t   res
);

	logic                                one_shot_q;
	logic [rdct_pkg::DATA_WIDTH-1:0]     calib_q;
	logic                                enable_q, int_en_q, clk_sel_q, flag_q;
	logic [rdct_pkg::COUNTER_WIDTH-1:0]  reload_q, current_q;
	logic [rdct_pkg::PRESCALE_WIDTH-1:0] presc_q;

	logic                                enable_d, int_en_d, clk_sel_d, flag_d;
	logic [rdct_pkg::COUNTER_WIDTH-1:0]  reload_d, current_d;
	logic [rdct_pkg::PRESCALE_WIDTH-1:0] presc_d;
	logic                                do_step;
	logic                                irq;
	logic [rdct_pkg::DATA_WIDTH-1:0]     rd;
	logic [rdct_pkg::PRESCALE_WIDTH:0]   presc_inc;

	assign presc_inc = {1'b0, presc_q} + 1'b1;

	always_comb begin
		enable_d  = enable_q;
		int_en_d  = int_en_q;
		clk_sel_d = clk_sel_q;
		flag_d    = flag_q;
		reload_d  = reload_q;
		current_d = current_q;
		presc_d   = presc_q;
		do_step   = 1'b0;
		irq       = 1'b0;
		rd        = '0;
		case (req_s1.cmd)
			rdct_pkg::CMD_TICK: begin
				if (enable_q) begin
					if (clk_sel_q) begin
						do_step = 1'b1;
					end else if (presc_inc >= (rdct_pkg::PRESCALE_WIDTH+1)'(rdct_pkg::PRESCALE_DIVIDE)) begin
						presc_d = '0;
						do_step = 1'b1;
					end else begin
						presc_d = presc_inc[rdct_pkg::PRESCALE_WIDTH-1:0];
					end
				end
			end
			rdct_pkg::CMD_WRITE: begin
				case (req_s1.sel)
					rdct_pkg::REG_CTRL: begin
						enable_d  = req_s1.data[rdct_pkg::CTRL_ENABLE_BIT];
						int_en_d  = req_s1.data[rdct_pkg::CTRL_INT_BIT];
						clk_sel_d = req_s1.data[rdct_pkg::CTRL_CLOCK_BIT];
					end
					rdct_pkg::REG_RELOAD: begin
						reload_d = req_s1.data[rdct_pkg::COUNTER_WIDTH-1:0];
					end
					rdct_pkg::REG_CURRENT: begin
						current_d = '0;
						flag_d    = 1'b0;
					end
					default: begin
					end
				endcase
			end
			rdct_pkg::CMD_READ: begin
				case (req_s1.sel)
					rdct_pkg::REG_CTRL: begin
						rd[rdct_pkg::CTRL_ENABLE_BIT] = enable_q;
						rd[rdct_pkg::CTRL_INT_BIT]    = int_en_q;
						rd[rdct_pkg::CTRL_CLOCK_BIT]  = clk_sel_q;
						rd[rdct_pkg::CTRL_FLAG_BIT]   = flag_q;
						flag_d = 1'b0;
					end
					rdct_pkg::REG_RELOAD:  rd = rdct_pkg::DATA_WIDTH'(reload_q);
					rdct_pkg::REG_CURRENT: rd = rdct_pkg::DATA_WIDTH'(current_q);
					default:               rd = calib_q;
				endcase
			end
			default: begin
			end
		endcase

		if (do_step) begin
			if (current_q == '0) begin
				current_d = reload_q;
			end else begin
				current_d = current_q - 1'b1;
				if (current_q == rdct_pkg::COUNTER_WIDTH'(1)) begin
					flag_d = 1'b1;
					irq    = int_en_q;
					// single interval expiry stops and clears the timer
					if (one_shot_q) begin
						enable_d  = 1'b0;
						int_en_d  = 1'b0;
						reload_d  = '0;
						current_d = '0;
						flag_d    = 1'b0;
						presc_d   = '0;
					end
				end
			end
		end
	end

	assign res.read_data = rd;
	assign res.irq       = irq;
	assign res.flag      = flag_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_shot_q <= 1'b0;
			calib_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				rdct_pkg::CFG_ONE_SHOT: one_shot_q <= cfg_wdata[0];
				default:                calib_q    <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			int_en_q  <= 1'b0;
			clk_sel_q <= 1'b0;
			flag_q    <= 1'b0;
			reload_q  <= '0;
			current_q <= '0;
			presc_q   <= '0;
		end else if (flow.valid && flow.advance) begin
			enable_q  <= enable_d;
			int_en_q  <= int_en_d;
			clk_sel_q <= clk_sel_d;
			flag_q    <= flag_d;
			reload_q  <= reload_d;
			current_q <= current_d;
			presc_q   <= presc_d;
		end
	end

endmodule
`default_nettype wire

[rtl/rdct_out_stage.sv]
// result register stage
`default_nettype none
module rdct_out_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       valid_s1,
	input  wire rdct_pkg::res_t res,
	output logic            advance,
	output logic            out_valid,
	input  wire logic       out_stall,
	output rdct_pkg::res_t  res_s2
);

	logic valid_s2;

	assign advance   = !valid_s2 || !out_stall;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= res;
		end
	end

endmodule
`default_nettype wire

[rtl/rdct_checker.sv]
// port-level checks for the timer top level, with its bind
`default_nettype none
module rdct_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] read_data,
	input wire logic        irq_request,
	input wire logic        count_flag
);

	// a request can only be held off while a result waits downstream
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a waiting result");

	// interrupt only comes from ticks, which return no read data
	a_irq_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && irq_request) |-> (read_data == 32'd0))
		else $error("interrupt result carries read data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(read_data)
			&& $stable(irq_request) && $stable(count_flag)))
		else $error("stalled result changed");

	// with nothing offered and nothing pending, no result can appear
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_valid && !in_stall && !out_valid) ##1 (!in_valid && !out_valid)
			|=> !out_valid)
		else $error("result without request");

endmodule

bind reloading_down_counter_timer_unit rdct_checker u_rdct_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.read_data   (read_data),
	.irq_request (irq_request),
	.count_flag  (count_flag)
);
`default_nettype wire
